// ----- rtl/core/ea2bv_pkg.sv -----
// ea2bv_pkg: shared types, constants and fixed-point helpers for the
// Euler-angle to basis-vector pipeline. No dependencies.
`default_nettype none

package ea2bv_pkg;

  // Number formats
  localparam int ANGLE_FRAC_BITS = 6;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int Q_W             = 31;           // unsigned Q30 magnitude, holds 1.0
  localparam int U_W             = 17;           // octant angle in angle units
  localparam int RED_W           = 20;           // angle reduced into one turn
  localparam int RAD_W           = 25;
  localparam int PROD_W          = U_W + RAD_W;

  typedef logic [Q_W-1:0]      uq30_t;
  typedef logic signed [Q_W:0] sq30_t;

  localparam uq30_t            Q_ONE       = uq30_t'(1) << 30;
  localparam logic [RAD_W-1:0] RAD_PER_DEG = 25'd18740330;   // pi/180 in Q30

  localparam int FULL_TURN = 360 << ANGLE_FRAC_BITS;
  localparam int QUARTER   = 90 << ANGLE_FRAC_BITS;
  localparam int HALF_Q    = 45 << ANGLE_FRAC_BITS;
  localparam int RAD_RND   = (ANGLE_FRAC_BITS == 0) ? 0 : (1 << (ANGLE_FRAC_BITS - 1));

  // Horner divisors, innermost first
  localparam int N_SIN = 4;
  localparam int N_COS = 5;
  localparam int SIN_DIV [N_SIN] = '{72, 42, 20, 6};
  localparam int COS_DIV [N_COS] = '{90, 56, 30, 12, 2};

  typedef struct packed {
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic signed [15:0] roll_deg;
  } ea2bv_in_t;

  typedef struct packed {
    logic signed [15:0] fwd_x;
    logic signed [15:0] fwd_y;
    logic signed [15:0] fwd_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
  } ea2bv_out_t;

  // Octant info that rides along the polynomial pipeline
  typedef struct packed {
    uq30_t      x;
    logic [1:0] quad;
    logic       swap;
  } ea2bv_side_t;

  // Unsigned Q30 product, rounded half up
  function automatic uq30_t umul30(uq30_t a, uq30_t b);
    logic [2*Q_W-1:0] p;
    p = a * b;
    p = p + ((2*Q_W)'(1) << 29);
    return uq30_t'(p >> 30);
  endfunction

  // Signed Q30 product, rounded half away from zero
  function automatic sq30_t smul30(sq30_t a, sq30_t b);
    logic [Q_W-1:0]   ma;
    logic [Q_W-1:0]   mb;
    logic [2*Q_W-1:0] p;
    sq30_t            m;
    logic             neg;
    neg = a[Q_W] ^ b[Q_W];
    ma  = a[Q_W] ? Q_W'(-a) : Q_W'(a);
    mb  = b[Q_W] ? Q_W'(-b) : Q_W'(b);
    p   = ma * mb;
    p   = p + ((2*Q_W)'(1) << 29);
    m   = sq30_t'(p >> 30);
    return neg ? -m : m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ea2bv_poly_step.sv -----
// ea2bv_poly_step: one Horner step t' = 1 - (x2*t)/DIV in three stages.
// Depends on ea2bv_pkg.
`default_nettype none

module ea2bv_poly_step
  import ea2bv_pkg::*;
#(
  parameter int DIV = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire uq30_t       x2_i,
  input  wire uq30_t       t_i,
  input  wire ea2bv_side_t side_i,
  output logic             valid_o,
  output uq30_t            x2_o,
  output uq30_t            t_o,
  output ea2bv_side_t      side_o
);

  localparam logic [31:0] RECIP = 32'((64'(1) << 32) / DIV);
  localparam uq30_t       DIV_C = uq30_t'(DIV);

  logic [2:0]        vld_q;
  uq30_t             m1_q, m2_q, x2a_q, x2b_q, t_q, x2c_q;
  logic [Q_W+31:0]   p_q;
  ea2bv_side_t       sd1_q, sd2_q, sd3_q;

  uq30_t             q0, rem, quo;

  // Reciprocal quotient, at most one short
  always_comb begin
    q0  = uq30_t'(p_q >> 32);
    rem = m2_q - q0 * DIV_C;
    quo = (rem >= DIV_C) ? q0 + uq30_t'(1) : q0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    // product
    m1_q  <= umul30(x2_i, t_i);
    x2a_q <= x2_i;
    sd1_q <= side_i;
    // reciprocal multiply
    p_q   <= m1_q * RECIP;
    m2_q  <= m1_q;
    x2b_q <= x2a_q;
    sd2_q <= sd1_q;
    // correct and subtract
    t_q   <= Q_ONE - quo;
    x2c_q <= x2b_q;
    sd3_q <= sd2_q;
  end

  assign valid_o = vld_q[2];
  assign x2_o    = x2c_q;
  assign t_o     = t_q;
  assign side_o  = sd3_q;

endmodule

`default_nettype wire

// ----- rtl/core/ea2bv_sincos.sv -----
// ea2bv_sincos: pipelined sine and cosine of one angle, 21 stages.
// Depends on ea2bv_pkg and ea2bv_poly_step.
`default_nettype none

module ea2bv_sincos
  import ea2bv_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  input  wire logic signed [15:0] angle_i,
  output logic                    valid_o,
  output sq30_t                   sin_o,
  output sq30_t                   cos_o
);

  localparam logic signed [RED_W:0] FULL_S = (RED_W+1)'(FULL_TURN);

  // Range reduction
  logic signed [RED_W:0] a_s, r0, r1, r2;
  always_comb begin
    a_s = (RED_W+1)'(angle_i);
    r0  = (a_s < 0) ? a_s + FULL_S : a_s;
    r1  = (r0 < 0) ? r0 + FULL_S : r0;
    r2  = (r1 >= FULL_S) ? r1 - FULL_S : r1;
  end

  logic [4:0]         vr_q;
  logic [RED_W-1:0]   red_q;
  logic [U_W-1:0]     u_q;
  logic [1:0]         qd2_q, qd3_q, qd4_q;
  logic               sw2_q, sw3_q, sw4_q;
  logic [PROD_W-1:0]  prod_q;
  uq30_t              x_q, x2_q;
  ea2bv_side_t        side_q;

  // Quadrant and octant fold
  logic [RED_W-1:0] m;
  logic [1:0]       qd;
  logic             sw;
  always_comb begin
    if (red_q >= RED_W'(3 * QUARTER)) begin
      qd = 2'd3; m = red_q - RED_W'(3 * QUARTER);
    end else if (red_q >= RED_W'(2 * QUARTER)) begin
      qd = 2'd2; m = red_q - RED_W'(2 * QUARTER);
    end else if (red_q >= RED_W'(QUARTER)) begin
      qd = 2'd1; m = red_q - RED_W'(QUARTER);
    end else begin
      qd = 2'd0; m = red_q;
    end
    sw = (m > RED_W'(HALF_Q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= '0;
    end else begin
      vr_q <= {vr_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    red_q  <= RED_W'(r2);
    u_q    <= sw ? U_W'(RED_W'(QUARTER) - m) : U_W'(m);
    qd2_q  <= qd;
    sw2_q  <= sw;
    prod_q <= u_q * RAD_PER_DEG;
    qd3_q  <= qd2_q;
    sw3_q  <= sw2_q;
    x_q    <= uq30_t'((prod_q + PROD_W'(RAD_RND)) >> ANGLE_FRAC_BITS);
    qd4_q  <= qd3_q;
    sw4_q  <= sw3_q;
    x2_q   <= umul30(x_q, x_q);
    side_q <= '{x: x_q, quad: qd4_q, swap: sw4_q};
  end

  // Sine polynomial chain
  logic [N_SIN:0] s_vld;
  uq30_t          s_x2 [N_SIN+1];
  uq30_t          s_t  [N_SIN+1];
  ea2bv_side_t    s_sd [N_SIN+1];
  assign s_vld[0] = vr_q[4];
  assign s_x2[0]  = x2_q;
  assign s_t[0]   = Q_ONE;
  assign s_sd[0]  = side_q;

  for (genvar i = 0; i < N_SIN; i++) begin : g_sin
    ea2bv_poly_step #(.DIV(SIN_DIV[i])) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (s_vld[i]),
      .x2_i    (s_x2[i]),
      .t_i     (s_t[i]),
      .side_i  (s_sd[i]),
      .valid_o (s_vld[i+1]),
      .x2_o    (s_x2[i+1]),
      .t_o     (s_t[i+1]),
      .side_o  (s_sd[i+1])
    );
  end

  // Cosine polynomial chain, one step longer
  uq30_t c_x2 [N_COS+1];
  uq30_t c_t  [N_COS+1];
  assign c_x2[0] = x2_q;
  assign c_t[0]  = Q_ONE;

  for (genvar i = 0; i < N_COS; i++) begin : g_cos
    ea2bv_poly_step #(.DIV(COS_DIV[i])) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vr_q[4]),
      .x2_i    (c_x2[i]),
      .t_i     (c_t[i]),
      .side_i  (side_q),
      .valid_o (),
      .x2_o    (c_x2[i+1]),
      .t_o     (c_t[i+1]),
      .side_o  ()
    );
  end

  // Final sine multiply, then two stages to line up with the cosine
  logic [3:0]  vf_q;
  uq30_t       sf_q, sd1_q, sd2_q;
  logic [1:0]  qf_q, q1_q, q2_q;
  logic        wf_q, w1_q, w2_q;
  sq30_t       sin_q, cos_q;

  // Octant swap and quadrant signs
  sq30_t s0, c0, s_m, c_m;
  always_comb begin
    s0 = w2_q ? sq30_t'(c_t[N_COS]) : sq30_t'(sd2_q);
    c0 = w2_q ? sq30_t'(sd2_q) : sq30_t'(c_t[N_COS]);
    case (q2_q)
      2'd0:    begin s_m = s0;  c_m = c0;  end
      2'd1:    begin s_m = c0;  c_m = -s0; end
      2'd2:    begin s_m = -s0; c_m = -c0; end
      default: begin s_m = -c0; c_m = s0;  end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= '0;
    end else begin
      vf_q <= {vf_q[2:0], s_vld[N_SIN]};
    end
  end

  always_ff @(posedge clk_i) begin
    sf_q  <= umul30(s_sd[N_SIN].x, s_t[N_SIN]);
    qf_q  <= s_sd[N_SIN].quad;
    wf_q  <= s_sd[N_SIN].swap;
    sd1_q <= sf_q;
    q1_q  <= qf_q;
    w1_q  <= wf_q;
    sd2_q <= sd1_q;
    q2_q  <= q1_q;
    w2_q  <= w1_q;
    sin_q <= s_m;
    cos_q <= c_m;
  end

  assign valid_o = vf_q[3];
  assign sin_o   = sin_q;
  assign cos_o   = cos_q;

  // Checks
  sq30_t q_one_s;
  assign q_one_s = sq30_t'(Q_ONE);

  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sin_o <= q_one_s) && (sin_o >= -q_one_s))
    else $error("sine out of unit range");
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (cos_o <= q_one_s) && (cos_o >= -q_one_s))
    else $error("cosine out of unit range");
  a_chain_lined_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_vld[N_SIN] |-> $past(vr_q[4], 3 * N_SIN))
    else $error("sine chain valid out of step");

endmodule

`default_nettype wire

// ----- rtl/core/ea2bv_combine.sv -----
// ea2bv_combine: products and sums that form the nine basis components,
// then rounding and saturation; four stages. Depends on ea2bv_pkg.
`default_nettype none

module ea2bv_combine
  import ea2bv_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire sq30_t sp_i,
  input  wire sq30_t cp_i,
  input  wire sq30_t sy_i,
  input  wire sq30_t cy_i,
  input  wire sq30_t sr_i,
  input  wire sq30_t cr_i,
  output logic       valid_o,
  output ea2bv_out_t out_o
);

  localparam int              S_W     = Q_W + 3;
  localparam int              OUT_SH  = 30 - OUT_FRAC_BITS;
  localparam int              OUT_RND = (OUT_SH == 0) ? 0 : (1 << (OUT_SH - 1));
  localparam logic [S_W-1:0]  LIM     = S_W'(1) << OUT_FRAC_BITS;

  function automatic logic signed [15:0] to_out(logic signed [S_W-1:0] v);
    logic [S_W-1:0] mag;
    logic [S_W-1:0] r;
    mag = v[S_W-1] ? S_W'(-v) : S_W'(v);
    r   = (mag + S_W'(OUT_RND)) >> OUT_SH;
    if (r > LIM) r = LIM;
    if (v[S_W-1]) begin
      if (r > S_W'(32768)) r = S_W'(32768);
      return 16'(-r);
    end else begin
      if (r > S_W'(32767)) r = S_W'(32767);
      return 16'(r);
    end
  endfunction

  logic [3:0] vld_q;

  // Stage 1: pairwise products
  sq30_t srsp_q, crsp_q, fx1_q, fy1_q, sp1_q, rz1_q, uz1_q;
  sq30_t crsy_q, crcy_q, srsy_q, srcy_q, sy1_q, cy1_q;
  // Stage 2: triple products
  sq30_t a1_q, a2_q, a3_q, a4_q;
  sq30_t fx2_q, fy2_q, sp2_q, rz2_q, uz2_q, crsy2_q, crcy2_q, srsy2_q, srcy2_q;
  // Stage 3: sums
  logic signed [S_W-1:0] sum_q [9];
  ea2bv_out_t            out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    srsp_q  <= smul30(sr_i, sp_i);
    crsp_q  <= smul30(cr_i, sp_i);
    fx1_q   <= smul30(cp_i, cy_i);
    fy1_q   <= smul30(cp_i, sy_i);
    sp1_q   <= sp_i;
    rz1_q   <= smul30(sr_i, cp_i);
    uz1_q   <= smul30(cr_i, cp_i);
    crsy_q  <= smul30(cr_i, sy_i);
    crcy_q  <= smul30(cr_i, cy_i);
    srsy_q  <= smul30(sr_i, sy_i);
    srcy_q  <= smul30(sr_i, cy_i);
    sy1_q   <= sy_i;
    cy1_q   <= cy_i;

    a1_q    <= smul30(srsp_q, cy1_q);
    a2_q    <= smul30(srsp_q, sy1_q);
    a3_q    <= smul30(crsp_q, cy1_q);
    a4_q    <= smul30(crsp_q, sy1_q);
    fx2_q   <= fx1_q;
    fy2_q   <= fy1_q;
    sp2_q   <= sp1_q;
    rz2_q   <= rz1_q;
    uz2_q   <= uz1_q;
    crsy2_q <= crsy_q;
    crcy2_q <= crcy_q;
    srsy2_q <= srsy_q;
    srcy2_q <= srcy_q;

    sum_q[0] <= S_W'(fx2_q);
    sum_q[1] <= S_W'(fy2_q);
    sum_q[2] <= -S_W'(sp2_q);
    sum_q[3] <= S_W'(crsy2_q) - S_W'(a1_q);
    sum_q[4] <= -S_W'(a2_q) - S_W'(crcy2_q);
    sum_q[5] <= -S_W'(rz2_q);
    sum_q[6] <= S_W'(a3_q) + S_W'(srsy2_q);
    sum_q[7] <= S_W'(a4_q) - S_W'(srcy2_q);
    sum_q[8] <= S_W'(uz2_q);

    out_q.fwd_x   <= to_out(sum_q[0]);
    out_q.fwd_y   <= to_out(sum_q[1]);
    out_q.fwd_z   <= to_out(sum_q[2]);
    out_q.right_x <= to_out(sum_q[3]);
    out_q.right_y <= to_out(sum_q[4]);
    out_q.right_z <= to_out(sum_q[5]);
    out_q.up_x    <= to_out(sum_q[6]);
    out_q.up_y    <= to_out(sum_q[7]);
    out_q.up_z    <= to_out(sum_q[8]);
  end

  assign valid_o = vld_q[3];
  assign out_o   = out_q;

endmodule

`default_nettype wire

// ----- rtl/core/euler_angles_to_basis_vectors.sv -----
// euler_angles_to_basis_vectors: top level, three sine/cosine pipelines
// feeding the basis combiner. Depends on ea2bv_pkg, ea2bv_sincos, ea2bv_combine.
//
// Usage:
//   Input channel: drive in_i (pitch, yaw, roll in degrees times 64) and
//   raise start_i; a transfer happens at each rising edge with start_i high
//   and busy_o low. busy_o never rises, so one item may enter every cycle.
//   Output channel: valid_o strobes for one cycle with out_o holding the
//   forward, right and up vectors (Q1.14). The receiver cannot hold a result
//   off; every result is shown exactly once.
//   Pipeline: a transfer passes through range reduction, polynomial
//   sine/cosine with its five-step cosine Horner chain, and quadrant fold,
//   then through products, sums and rounding, before the strobe.
//   Throughput: one item per cycle, set by the fully pipelined multipliers.
//   Reset: clears every valid bit; items in flight are dropped and no
//   result appears until a new transfer has traveled the pipeline.
`default_nettype none

module euler_angles_to_basis_vectors
  import ea2bv_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire ea2bv_in_t in_i,
  output logic           valid_o,
  output ea2bv_out_t     out_o
);

  localparam int LATENCY = 25;

  logic  acc;
  logic  vp;
  sq30_t sp, cp, sy, cy, sr, cr;

  assign busy_o = 1'b0;
  assign acc    = start_i & ~busy_o;

  ea2bv_sincos u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .angle_i (in_i.pitch_deg),
    .valid_o (vp),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  ea2bv_sincos u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .angle_i (in_i.yaw_deg),
    .valid_o (),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  ea2bv_sincos u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (acc),
    .angle_i (in_i.roll_deg),
    .valid_o (),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  ea2bv_combine u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp),
    .sp_i    (sp),
    .cp_i    (cp),
    .sy_i    (sy),
    .cy_i    (cy),
    .sr_i    (sr),
    .cr_i    (cr),
    .valid_o (valid_o),
    .out_o   (out_o)
  );

  // Checks
  a_result_has_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(acc, LATENCY))
    else $error("result without a matching transfer");
  a_level_pitch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(in_i.pitch_deg, LATENCY) == 16'sd0) |-> out_o.fwd_z == 16'sd0)
    else $error("zero pitch gave nonzero forward z");
  a_level_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && $past(in_i.roll_deg, LATENCY) == 16'sd0) |-> out_o.right_z == 16'sd0)
    else $error("zero roll gave nonzero right z");

endmodule

`default_nettype wire
